[hw/rtl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/spcd_pkg.sv]
`default_nettype none
package spcd_pkg;

	// packet byte positions
	localparam int POS_W        = 5;
	localparam logic [POS_W-1:0] POS_BATT    = 5'd7;
	localparam logic [POS_W-1:0] POS_TEMP_LO = 5'd10;
	localparam logic [POS_W-1:0] POS_TEMP_HI = 5'd11;
	localparam logic [POS_W-1:0] POS_CRC_END = 5'd16;
	localparam logic [POS_W-1:0] POS_CRC_LO  = 5'd16;
	localparam logic [POS_W-1:0] POS_CRC_HI  = 5'd17;
	localparam logic [POS_W-1:0] POS_IDLE    = 5'd18;

	// configuration registers
	localparam int REG_IDX_W = 1;
	localparam int REG_W     = 16;
	localparam logic [REG_IDX_W-1:0] REG_CRC_POLY = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_CRC_INIT = 1'd1;
	localparam logic [REG_W-1:0] CRC_POLY_RST = 16'hA001;
	localparam logic [REG_W-1:0] CRC_INIT_RST = 16'h0000;

	// beat widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [REG_W-1:0] crc_t;

	// reflected crc-16 over one byte, lsb first, eight unrolled shifts
	function automatic crc_t crc_byte(input crc_t rem_in, input logic [7:0] b,
		input crc_t poly);
		crc_t rem;
		rem = rem_in ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (rem[0]) begin
				rem = (rem >> 1) ^ poly;
			end else begin
				rem = rem >> 1;
			end
		end
		return rem;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/sensor_packet_crc_decoder_unit.sv]
// Sensor packet CRC decoder.
// Input beats carry one packet byte each (s_axis_tdata) with tuser set on
// byte 0 of a packet. Bytes 0 to 15 run through a reflected CRC-16 with the
// polynomial and seed from the cfg port; bytes 16 and 17 hold the received
// CRC, little endian. After byte 17 one output beat comes out with the match
// flag in tuser and temperature (bytes 11:10) and battery (byte 7) in tdata,
// both zero when the CRC does not match. Bytes outside a packet are dropped.
// Throughput: one byte per cycle, set by the unrolled CRC step, save where
// the last byte stalls as below. A packet's last byte reaches the output
// through the input register, then the result register. The input register
// frees as its byte is processed; only the last byte of a packet waits while
// an undelivered result is held, so a stalled receiver blocks input only at
// the end of the next packet. Reset: polynomial 0xA001, seed 0, no packet in
// progress, both beat registers empty. cfg writes take effect the edge they
// are presented; the seed is sampled at each packet start.
`default_nettype none
module sensor_packet_crc_decoder_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// slave stream
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [spcd_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] data_byte
	input  wire logic [0:0]                       s_axis_tuser,  // [0] packet_start
	// master stream
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [spcd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // [15:0] temperature_tenths,
	                                                             // [23:16] battery_percent
	output logic [0:0]                            m_axis_tuser,  // [0] crc_ok
	// configuration write port
	input  wire logic                             cfg_we,
	input  wire logic [spcd_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [spcd_pkg::REG_W-1:0]       cfg_data
);
	import spcd_pkg::*;

	crc_t       poly_q;
	crc_t       init_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	pos_t       pos_q;
	crc_t       crc_q;
	logic [7:0] rx_lo_q;
	logic [15:0] temp_q;
	logic [7:0] batt_q;
	logic       out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic       out_ok_q;

	pos_t       pos_eff;
	crc_t       crc_base;
	crc_t       crc_next;
	logic       active;
	logic       is_last;
	logic       out_free;
	logic       advance;
	logic       ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= CRC_POLY_RST;
			init_q <= CRC_INIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_CRC_POLY) begin
				poly_q <= cfg_data;
			end else if (cfg_index == REG_CRC_INIT) begin
				init_q <= cfg_data;
			end
		end
	end

	// byte decode for the registered beat
	always_comb begin
		pos_eff  = start_s1 ? '0 : pos_q;
		crc_base = start_s1 ? init_q : crc_q;
		active   = start_s1 || (pos_q != POS_IDLE);
		is_last  = active && (pos_eff == POS_CRC_HI);
		crc_next = (pos_eff < POS_CRC_END) ? crc_byte(crc_base, byte_s1, poly_q) : crc_base;
		ok       = ({byte_s1, rx_lo_q} == crc_base);
		out_free = !out_valid_q || m_axis_tready;
		advance  = valid_s1 && (!is_last || out_free);
	end

	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser[0];
		end
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_IDLE;
			crc_q   <= '0;
			rx_lo_q <= '0;
			temp_q  <= '0;
			batt_q  <= '0;
		end else if (advance && active) begin
			pos_q <= is_last ? POS_IDLE : pos_eff + 5'd1;
			crc_q <= crc_next;
			if (pos_eff == POS_BATT) begin
				batt_q <= byte_s1;
			end
			if (pos_eff == POS_TEMP_LO) begin
				temp_q[7:0] <= byte_s1;
			end
			if (pos_eff == POS_TEMP_HI) begin
				temp_q[15:8] <= byte_s1;
			end
			if (pos_eff == POS_CRC_LO) begin
				rx_lo_q <= byte_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last) begin
			out_ok_q   <= ok;
			out_data_q <= ok ? {batt_q, temp_q} : '0;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_ok_q;

endmodule
`default_nettype wire

[hw/rtl/spcd_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module spcd_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic [0:0]                       s_axis_tuser,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [spcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input wire logic [0:0]                       m_axis_tuser
);
	import spcd_pkg::*;

	logic in_end;
	logic out_stall;
	assign in_end    = s_axis_tvalid && s_axis_tready && !s_axis_tuser[0];
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
	`ASSERT_NEXT(a_flag_hold, clk, arst_n, out_stall, $stable(m_axis_tuser))

	// failed check reports zeros
	`ASSERT_IMPL(a_bad_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)

	// a new result follows a non-start input beat taken through the input and result registers
	`ASSERT_IMPL(a_rise_after_end, clk, arst_n, $rose(m_axis_tvalid), $past(in_end, 2))

endmodule

bind sensor_packet_crc_decoder_unit spcd_checker u_spcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
